### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HPO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HPO_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/hpo_pkg.sv
// Shared constants, register codes and control types of the peak orientation block.
`timescale 1ns / 1ps

package hpo_pkg;

   // default sizing
   localparam int MAX_BINS_DEF   = 256;
   localparam int MAX_PEAKS_DEF  = 8;
   localparam int MAX_WINDOW_DEF = 15;

   // field widths
   localparam int BIN_W      = 16;
   localparam int ANGLE_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int USED_W     = 4;
   localparam int RANGE_W    = 9;
   localparam int FACTOR_W   = 17;
   localparam int TOP_W      = 4;
   localparam int WIN_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_PEAKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW      = 3'd4;

   // register reset values
   localparam logic [RANGE_W-1:0]  RANGE_START_RST = 9'd0;
   localparam logic [RANGE_W-1:0]  RANGE_END_RST   = 9'd256;
   localparam logic [FACTOR_W-1:0] SMOOTHING_RST   = 17'd19661;
   localparam logic [TOP_W-1:0]    TOP_PEAKS_RST   = 4'd3;
   localparam logic [WIN_W-1:0]    WINDOW_RST      = 4'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_SMOOTHED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RESTART  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HELD     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DEFAULT  = 2'd3;

   // angles in 1/256 degree
   localparam logic [ANGLE_W-1:0] DEG45  = 16'd11520;
   localparam logic [ANGLE_W-1:0] DEG90  = 16'd23040;
   localparam logic [ANGLE_W-1:0] DEG180 = 16'd46080;

   // 2*180*256 = 45 << 11
   localparam int SCALE_W     = 6;
   localparam int BIN_SCALE   = 45;
   localparam int SCALE_SHIFT = 11;

   // EMA weights, Q1.16
   localparam logic [FACTOR_W-1:0] Q_ONE    = 17'd65536;
   localparam int                  Q_FRAC   = 16;

   typedef struct packed {
      logic clear;
      logic offer;
   } pk_ctrl_type;

endpackage

### rtl/hpo_bin_mem.sv
// Histogram bin memory: one write port, one registered read port.
`timescale 1ns / 1ps

module hpo_bin_mem #(
   parameter int DEPTH  = hpo_pkg::MAX_BINS_DEF,
   parameter int ADDR_W = $clog2(hpo_pkg::MAX_BINS_DEF),
   parameter int DATA_W = hpo_pkg::BIN_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hpo_peak_list.sv
// Sorted list of the strongest peaks, one insertion per cycle.
`timescale 1ns / 1ps

module hpo_peak_list #(
   parameter int MAX_PEAKS = hpo_pkg::MAX_PEAKS_DEF,
   parameter int AW        = 8,
   parameter int VW        = 20,
   parameter int PW        = 4,
   parameter int PIW       = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hpo_pkg::pk_ctrl_type ctrl,
   input  logic [AW-1:0]        of_idx,
   input  logic [AW-1:0]        of_rank,
   input  logic [VW-1:0]        of_val,
   input  logic [PW-1:0]        limit,
   input  logic [PIW-1:0]       rd_sel,
   output logic [PW-1:0]        held,
   output logic [AW-1:0]        rd_idx,
   output logic [VW-1:0]        rd_val
);

   logic [AW-1:0] idx_ff  [MAX_PEAKS];
   logic [AW-1:0] rank_ff [MAX_PEAKS];
   logic [VW-1:0] val_ff  [MAX_PEAKS];
   logic [PW-1:0] held_ff;
   logic [PW-1:0] pos;
   logic          ins;

   // list is sorted, so the entries that beat the offer form a prefix
   always_comb begin
      pos = '0;
      for (int k = 0; k < MAX_PEAKS; k++) begin
         if ((PW'(k) < held_ff) &&
             ((val_ff[k] > of_val) ||
              ((val_ff[k] == of_val) && (rank_ff[k] < of_rank)))) begin
            pos = pos + PW'(1);
         end
      end
      ins = ctrl.offer && (pos < limit);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         held_ff <= '0;
      end else if (ins && (held_ff < limit)) begin
         held_ff <= held_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ins) begin
         if (pos == '0) begin
            idx_ff[0]  <= of_idx;
            rank_ff[0] <= of_rank;
            val_ff[0]  <= of_val;
         end
         for (int k = 1; k < MAX_PEAKS; k++) begin
            if (PW'(k) == pos) begin
               idx_ff[k]  <= of_idx;
               rank_ff[k] <= of_rank;
               val_ff[k]  <= of_val;
            end else if (PW'(k) > pos) begin
               idx_ff[k]  <= idx_ff[k-1];
               rank_ff[k] <= rank_ff[k-1];
               val_ff[k]  <= val_ff[k-1];
            end
         end
      end
   end

   assign held   = held_ff;
   assign rd_idx = idx_ff[rd_sel];
   assign rd_val = val_ff[rd_sel];

endmodule

### rtl/hpo_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hpo_divider #(
   parameter int NW = 50,
   parameter int DW = 34,
   parameter int QW = hpo_pkg::ANGLE_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [QW-1:0] quot
);

   localparam int CNTW = $clog2(NW + 1);

   logic [NW-1:0]   x_ff;
   logic [DW-1:0]   d_ff;
   logic [DW-1:0]   r_ff;
   logic [QW-1:0]   q_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DW:0]     r_shift;
   logic            fits;

   always_comb begin
      r_shift = {r_ff, x_ff[NW-1]};
      fits    = r_shift >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= num;
         d_ff <= den;
         r_ff <= '0;
         q_ff <= '0;
      end else if (busy_ff) begin
         x_ff <= {x_ff[NW-2:0], 1'b0};
         // remainder stays below the divisor, so DW bits hold it
         r_ff <= fits ? DW'(r_shift - {1'b0, d_ff}) : r_shift[DW-1:0];
         q_ff <= {q_ff[QW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### rtl/histogram_peak_orientation.sv
// Top level: bin loading, window smoothing, peak search, weighted mean and EMA.
// Loading: one bin per cycle while req_stall is low. The single memory read port and the 50-step
//   divider set the time from the last bin to rsp_valid, which grows with the half window,
//   the slice length and the peaks kept, and is shorter on a restart.
// Throughput: one histogram at a time; req_stall is high from the last bin to the result.
// Reset: synchronous; clears bin count, previous angle and registers; bins are not cleared.
`timescale 1ns / 1ps

module histogram_peak_orientation #(
   parameter int MAX_BINS   = hpo_pkg::MAX_BINS_DEF,
   parameter int MAX_PEAKS  = hpo_pkg::MAX_PEAKS_DEF,
   parameter int MAX_WINDOW = hpo_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hpo_pkg::BIN_W-1:0]      req_bin_value,
   input  logic                           req_last_bin,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hpo_pkg::ANGLE_W-1:0]    rsp_orientation,
   output logic [hpo_pkg::STATUS_W-1:0]   rsp_status,
   output logic [hpo_pkg::USED_W-1:0]     rsp_peaks_used,
   input  logic                           csr_we,
   input  logic [hpo_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpo_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW       = $clog2(MAX_BINS + 1);
   localparam int AW       = $clog2(MAX_BINS);
   localparam int HALF_MAX = MAX_WINDOW / 2;
   localparam int HWID     = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
   localparam int TW       = $clog2(2 * HALF_MAX + 2);
   localparam int VW       = hpo_pkg::BIN_W + $clog2(2 * HALF_MAX + 1);
   localparam int PW       = $clog2(MAX_PEAKS + 1);
   localparam int PIW      = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int LW       = (CW > hpo_pkg::RANGE_W) ? CW : hpo_pkg::RANGE_W;
   localparam int BMW      = AW + hpo_pkg::SCALE_W;
   localparam int PRW      = VW + BMW;
   localparam int NUMW     = PRW + PW;
   localparam int WSW      = VW + PW;
   localparam int DENW     = CW + WSW;
   localparam int XW       = ((NUMW + hpo_pkg::SCALE_SHIFT) > DENW ?
                              (NUMW + hpo_pkg::SCALE_SHIFT) : DENW) + 1;
   localparam int DVW      = DENW + 1;
   localparam int AG       = hpo_pkg::ANGLE_W;
   localparam int FW       = hpo_pkg::FACTOR_W;
   localparam int MW       = FW + AG;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_SETUP    = 5'd1;
   localparam logic [4:0] S_PREP     = 5'd2;
   localparam logic [4:0] S_INIT_RD  = 5'd3;
   localparam logic [4:0] S_INIT_AC  = 5'd4;
   localparam logic [4:0] S_STEP_RO  = 5'd5;
   localparam logic [4:0] S_STEP_RI  = 5'd6;
   localparam logic [4:0] S_STEP_AC  = 5'd7;
   localparam logic [4:0] S_EVAL     = 5'd8;
   localparam logic [4:0] S_LAST     = 5'd9;
   localparam logic [4:0] S_PEAKS    = 5'd10;
   localparam logic [4:0] S_MEAN_A   = 5'd11;
   localparam logic [4:0] S_MEAN_B   = 5'd12;
   localparam logic [4:0] S_MEAN_C   = 5'd13;
   localparam logic [4:0] S_DEN      = 5'd14;
   localparam logic [4:0] S_DIV_GO   = 5'd15;
   localparam logic [4:0] S_DIV_WAIT = 5'd16;
   localparam logic [4:0] S_EMA_A    = 5'd17;
   localparam logic [4:0] S_EMA_B    = 5'd18;
   localparam logic [4:0] S_EMA_C    = 5'd19;
   localparam logic [4:0] S_RESULT   = 5'd20;

   // configuration
   logic [hpo_pkg::RANGE_W-1:0] cfg_start_ff;
   logic [hpo_pkg::RANGE_W-1:0] cfg_end_ff;
   logic [FW-1:0]               cfg_factor_ff;
   logic [hpo_pkg::TOP_W-1:0]   cfg_top_ff;
   logic [hpo_pkg::WIN_W-1:0]   cfg_win_ff;

   // control and datapath
   logic [4:0]    state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] len_ff;
   logic [AW-1:0] start_ff;
   logic [HWID-1:0] half_ff;
   logic [HWID-1:0] hcnt_ff;
   logic [TW-1:0] taps_ff;
   logic [PW-1:0] limit_ff;
   logic [AW-1:0] ptr_ff;
   logic [AW-1:0] p0_ff;
   logic [AW-1:0] out_ptr_ff;
   logic [AW-1:0] in_ptr_ff;
   logic [AW-1:0] i_ff;
   logic [VW-1:0] acc_ff;
   logic [VW-1:0] sub_ff;
   logic [VW-1:0] s_prev_ff;
   logic [VW-1:0] s_prev2_ff;
   logic [PIW-1:0] k_ff;
   logic [VW-1:0]  v_ff;
   logic [BMW-1:0] bm_ff;
   logic [PRW-1:0] prod_ff;
   logic [NUMW-1:0] num_ff;
   logic [WSW-1:0]  wsum_ff;
   logic [DENW-1:0] den_ff;
   logic [AG-1:0]   cur_ff;
   logic [MW-1:0]   m1_ff;
   logic [MW-1:0]   m2_ff;
   logic [AG-1:0]   prev_ff;
   logic            pv_ff;
   logic [AG-1:0]   res_orient_ff;
   logic [hpo_pkg::STATUS_W-1:0] res_status_ff;
   logic [hpo_pkg::USED_W-1:0]   res_used_ff;
   logic            rsp_valid_ff;
   logic [AG-1:0]   rsp_orient_ff;
   logic [hpo_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [hpo_pkg::USED_W-1:0]   rsp_used_ff;

   // combinational
   logic          req_take;
   logic [CW-1:0] count_in;
   logic          mem_we;
   logic [AW-1:0] rd_ptr;
   logic [AW-1:0] rd_addr;
   logic [hpo_pkg::BIN_W-1:0] rd_data;
   logic [LW-1:0] lw_end;
   logic [LW-1:0] lw_len;
   logic [hpo_pkg::WIN_W-1:0] h_raw;
   logic [hpo_pkg::WIN_W-1:0] h_cap;
   logic [hpo_pkg::TOP_W:0]   top_ext;
   logic [PW-1:0] limit_in;
   logic [AW-1:0] ptr_dec;
   logic [AW-1:0] ptr_inc;
   logic [AW-1:0] out_inc;
   logic [AW-1:0] in_inc;
   logic [AW-1:0] cand;
   logic          cand_hit;
   logic          last_hit;
   logic          last_i;
   hpo_pkg::pk_ctrl_type pk_ctrl;
   logic [AW-1:0] of_idx;
   logic [AW-1:0] of_rank;
   logic [VW-1:0] of_val;
   logic [PW-1:0] held;
   logic [AW-1:0] pk_idx;
   logic [VW-1:0] pk_val;
   logic          div_start;
   logic          div_done;
   logic [AG-1:0] div_quot;
   logic [AG-1:0] cur_c;
   logic [AG-1:0] diff_c;
   logic [FW-1:0] alpha;
   logic [MW:0]   ema_sum;
   logic          out_free;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_ff  <= hpo_pkg::RANGE_START_RST;
         cfg_end_ff    <= hpo_pkg::RANGE_END_RST;
         cfg_factor_ff <= hpo_pkg::SMOOTHING_RST;
         cfg_top_ff    <= hpo_pkg::TOP_PEAKS_RST;
         cfg_win_ff    <= hpo_pkg::WINDOW_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            hpo_pkg::REG_RANGE_START: cfg_start_ff  <= csr_wdata[hpo_pkg::RANGE_W-1:0];
            hpo_pkg::REG_RANGE_END:   cfg_end_ff    <= csr_wdata[hpo_pkg::RANGE_W-1:0];
            hpo_pkg::REG_SMOOTHING:   cfg_factor_ff <= csr_wdata[FW-1:0];
            hpo_pkg::REG_TOP_PEAKS:   cfg_top_ff    <= csr_wdata[hpo_pkg::TOP_W-1:0];
            hpo_pkg::REG_WINDOW:      cfg_win_ff    <= csr_wdata[hpo_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- combinational helpers ----------------
   always_comb begin
      req_take = req_valid && !req_stall;
      mem_we   = req_take && (count_ff < CW'(MAX_BINS));
      count_in = mem_we ? count_ff + CW'(1) : count_ff;

      lw_end = (LW'(cfg_end_ff) < LW'(n_ff)) ? LW'(cfg_end_ff) : LW'(n_ff);
      lw_len = (LW'(cfg_start_ff) < lw_end) ? lw_end - LW'(cfg_start_ff) : '0;

      h_raw = (cfg_win_ff <= hpo_pkg::WIN_W'(1)) ? '0 : (cfg_win_ff >> 1);
      h_cap = (h_raw > hpo_pkg::WIN_W'(HALF_MAX)) ? hpo_pkg::WIN_W'(HALF_MAX) : h_raw;

      top_ext  = {1'b0, cfg_top_ff};
      if (top_ext == '0) begin
         limit_in = PW'(1);
      end else if (top_ext > (hpo_pkg::TOP_W + 1)'(MAX_PEAKS)) begin
         limit_in = PW'(MAX_PEAKS);
      end else begin
         limit_in = PW'(top_ext);
      end

      ptr_dec = (ptr_ff == '0) ? AW'(len_ff - CW'(1)) : ptr_ff - AW'(1);
      ptr_inc = (CW'(ptr_ff) == len_ff - CW'(1)) ? '0 : ptr_ff + AW'(1);
      out_inc = (CW'(out_ptr_ff) == len_ff - CW'(1)) ? '0 : out_ptr_ff + AW'(1);
      in_inc  = (CW'(in_ptr_ff) == len_ff - CW'(1)) ? '0 : in_ptr_ff + AW'(1);

      case (state_ff)
         S_STEP_RO: rd_ptr = out_ptr_ff;
         S_STEP_RI: rd_ptr = in_ptr_ff;
         default:   rd_ptr = ptr_ff;
      endcase
      rd_addr = start_ff + rd_ptr;

      last_i = (CW'(i_ff) == len_ff - CW'(1));
      cand   = i_ff - AW'(1);
      if (cand == '0) begin
         cand_hit = (i_ff != '0) && (s_prev_ff > acc_ff);
      end else begin
         cand_hit = (i_ff != '0) && (s_prev_ff > s_prev2_ff) && (s_prev_ff > acc_ff);
      end
      last_hit = s_prev_ff > s_prev2_ff;

      pk_ctrl.clear = (state_ff == S_SETUP);
      pk_ctrl.offer = ((state_ff == S_EVAL) && cand_hit) ||
                      ((state_ff == S_LAST) && last_hit);
      if (state_ff == S_LAST) begin
         of_idx  = AW'(len_ff - CW'(1));
         of_rank = AW'(1);
      end else begin
         of_idx  = cand;
         of_rank = (cand == '0) ? '0 : cand + AW'(1);
      end
      of_val = s_prev_ff;

      div_start = (state_ff == S_DIV_GO);
      cur_c     = (den_ff == '0) ? hpo_pkg::DEG90 : div_quot;
      diff_c    = (cur_c > prev_ff) ? cur_c - prev_ff : prev_ff - cur_c;

      alpha   = (cfg_factor_ff > hpo_pkg::Q_ONE) ? hpo_pkg::Q_ONE : cfg_factor_ff;
      ema_sum = (MW + 1)'(m1_ff) + (MW + 1)'(m2_ff) +
                (MW + 1)'(hpo_pkg::Q_ONE >> 1);

      out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign req_stall = (state_ff != S_IDLE);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         prev_ff  <= '0;
         pv_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               count_ff <= count_in;
               if (req_take && req_last_bin) begin
                  n_ff     <= count_in;
                  count_ff <= '0;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               len_ff   <= CW'(lw_len);
               start_ff <= AW'(cfg_start_ff);
               half_ff  <= HWID'(h_cap);
               hcnt_ff  <= HWID'(h_cap);
               limit_ff <= limit_in;
               ptr_ff   <= '0;
               state_ff <= (lw_len < LW'(2)) ? S_PEAKS : S_PREP;
            end
            S_PREP: begin
               // walk back half a window, wrapping in the slice
               if (hcnt_ff == '0) begin
                  p0_ff    <= ptr_ff;
                  taps_ff  <= TW'({half_ff, 1'b1});
                  acc_ff   <= '0;
                  state_ff <= S_INIT_RD;
               end else begin
                  ptr_ff  <= ptr_dec;
                  hcnt_ff <= hcnt_ff - HWID'(1);
               end
            end
            S_INIT_RD: begin
               ptr_ff   <= ptr_inc;
               taps_ff  <= taps_ff - TW'(1);
               state_ff <= S_INIT_AC;
            end
            S_INIT_AC: begin
               acc_ff <= acc_ff + VW'(rd_data);
               if (taps_ff == '0) begin
                  in_ptr_ff  <= ptr_ff;
                  out_ptr_ff <= p0_ff;
                  i_ff       <= '0;
                  state_ff   <= S_EVAL;
               end else begin
                  state_ff <= S_INIT_RD;
               end
            end
            S_STEP_RO: begin
               out_ptr_ff <= out_inc;
               state_ff   <= S_STEP_RI;
            end
            S_STEP_RI: begin
               sub_ff    <= VW'(rd_data);
               in_ptr_ff <= in_inc;
               state_ff  <= S_STEP_AC;
            end
            S_STEP_AC: begin
               // slide: drop the oldest tap, add the newest
               acc_ff   <= acc_ff - sub_ff + VW'(rd_data);
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               s_prev2_ff <= s_prev_ff;
               s_prev_ff  <= acc_ff;
               if (last_i) begin
                  state_ff <= S_LAST;
               end else begin
                  i_ff     <= i_ff + AW'(1);
                  state_ff <= S_STEP_RO;
               end
            end
            S_LAST: begin
               state_ff <= S_PEAKS;
            end
            S_PEAKS: begin
               k_ff    <= '0;
               num_ff  <= '0;
               wsum_ff <= '0;
               if (held == '0) begin
                  res_orient_ff <= pv_ff ? prev_ff : hpo_pkg::DEG90;
                  res_status_ff <= pv_ff ? hpo_pkg::STATUS_HELD : hpo_pkg::STATUS_DEFAULT;
                  res_used_ff   <= '0;
                  state_ff      <= S_RESULT;
               end else begin
                  state_ff <= S_MEAN_A;
               end
            end
            S_MEAN_A: begin
               bm_ff    <= BMW'(start_ff + pk_idx) * BMW'(hpo_pkg::BIN_SCALE);
               v_ff     <= pk_val;
               state_ff <= S_MEAN_B;
            end
            S_MEAN_B: begin
               prod_ff  <= PRW'(v_ff) * PRW'(bm_ff);
               state_ff <= S_MEAN_C;
            end
            S_MEAN_C: begin
               num_ff  <= num_ff + NUMW'(prod_ff);
               wsum_ff <= wsum_ff + WSW'(v_ff);
               if (PW'(k_ff) == held - PW'(1)) begin
                  state_ff <= S_DEN;
               end else begin
                  k_ff     <= k_ff + PIW'(1);
                  state_ff <= S_MEAN_A;
               end
            end
            S_DEN: begin
               den_ff   <= DENW'(n_ff) * DENW'(wsum_ff);
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  res_used_ff <= hpo_pkg::USED_W'(held);
                  cur_ff      <= cur_c;
                  if (!pv_ff || (diff_c > hpo_pkg::DEG45)) begin
                     prev_ff       <= cur_c;
                     pv_ff         <= 1'b1;
                     res_orient_ff <= cur_c;
                     res_status_ff <= hpo_pkg::STATUS_RESTART;
                     state_ff      <= S_RESULT;
                  end else begin
                     state_ff <= S_EMA_A;
                  end
               end
            end
            S_EMA_A: begin
               m1_ff    <= MW'(alpha) * MW'(cur_ff);
               state_ff <= S_EMA_B;
            end
            S_EMA_B: begin
               m2_ff    <= MW'(hpo_pkg::Q_ONE - alpha) * MW'(prev_ff);
               state_ff <= S_EMA_C;
            end
            S_EMA_C: begin
               prev_ff       <= ema_sum[hpo_pkg::Q_FRAC +: AG];
               res_orient_ff <= ema_sum[hpo_pkg::Q_FRAC +: AG];
               res_status_ff <= hpo_pkg::STATUS_SMOOTHED;
               state_ff      <= S_RESULT;
            end
            S_RESULT: begin
               // hold until the output register is free
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_RESULT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_RESULT) && out_free) begin
         rsp_orient_ff <= res_orient_ff;
         rsp_status_ff <= res_status_ff;
         rsp_used_ff   <= res_used_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_orientation = rsp_orient_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_peaks_used  = rsp_used_ff;

   // ---------------- units ----------------
   hpo_bin_mem #(
      .DEPTH  (MAX_BINS),
      .ADDR_W (AW),
      .DATA_W (hpo_pkg::BIN_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(count_ff)),
      .wr_data (req_bin_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hpo_peak_list #(
      .MAX_PEAKS (MAX_PEAKS),
      .AW        (AW),
      .VW        (VW),
      .PW        (PW),
      .PIW       (PIW)
   ) u_peaks (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (pk_ctrl),
      .of_idx  (of_idx),
      .of_rank (of_rank),
      .of_val  (of_val),
      .limit   (limit_ff),
      .rd_sel  (k_ff),
      .held    (held),
      .rd_idx  (pk_idx),
      .rd_val  (pk_val)
   );

   hpo_divider #(
      .NW (XW),
      .DW (DVW),
      .QW (AG)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ((XW'(num_ff) << hpo_pkg::SCALE_SHIFT) + XW'(den_ff)),
      .den   (DVW'(den_ff) << 1),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule

### rtl/hpo_checker.sv
// Port-level checks of the result channel, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpo_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [hpo_pkg::ANGLE_W-1:0]  rsp_orientation,
   input logic [hpo_pkg::STATUS_W-1:0] rsp_status,
   input logic [hpo_pkg::USED_W-1:0]   rsp_peaks_used
);

   logic v_none;
   logic v_some;
   logic v_dflt;
   logic used_none;
   logic at_90;
   logic in_range;
   logic stalled;
   logic [hpo_pkg::ANGLE_W+hpo_pkg::STATUS_W+hpo_pkg::USED_W-1:0] rsp_w;

   assign v_none    = rsp_valid && ((rsp_status == hpo_pkg::STATUS_HELD) ||
                                    (rsp_status == hpo_pkg::STATUS_DEFAULT));
   assign v_some    = rsp_valid && ((rsp_status == hpo_pkg::STATUS_SMOOTHED) ||
                                    (rsp_status == hpo_pkg::STATUS_RESTART));
   assign v_dflt    = rsp_valid && (rsp_status == hpo_pkg::STATUS_DEFAULT);
   assign used_none = (rsp_peaks_used == '0);
   assign at_90     = (rsp_orientation == hpo_pkg::DEG90);
   assign in_range  = (rsp_orientation <= hpo_pkg::DEG180);
   assign stalled   = rsp_valid && rsp_stall;
   assign rsp_w     = {rsp_orientation, rsp_status, rsp_peaks_used};

   `HPO_ASSERT_IMP(a_none_used, clock, reset, v_none, used_none, "peaks on a no-peak result")
   `HPO_ASSERT_IMP(a_peak_used, clock, reset, v_some, !used_none, "angle result without peaks")
   `HPO_ASSERT_IMP(a_default_angle, clock, reset, v_dflt, at_90, "default is not 90 degrees")
   `HPO_ASSERT_IMP(a_angle_range, clock, reset, rsp_valid, in_range, "orientation above 180")
   `HPO_ASSERT_NXT(a_hold, clock, reset, stalled, rsp_valid && $stable(rsp_w), "stall changed")

endmodule

bind histogram_peak_orientation hpo_checker u_hpo_checker (.*);
